[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is low.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/dlls_pkg.sv]
`default_nettype none
package dlls_pkg;

  localparam int unsigned LP_W   = 16;
  localparam int unsigned BW_W   = 6;
  localparam int unsigned VL_W   = 9;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CIDX_W = 2;

  // input action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  // result kind codes
  localparam logic KIND_PHASE = 1'b0;
  localparam logic KIND_REQ   = 1'b1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_DMA_CONTROL = 2'd0;
  localparam logic [CIDX_W-1:0] REG_NMI_ENABLE  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LIST_START  = 2'd2;

  // instruction opcodes (low nibble)
  localparam logic [3:0] OP_BLANK = 4'd0;
  localparam logic [3:0] OP_JUMP  = 4'd1;

  localparam logic [LP_W-1:0] LIST_PAGE_MASK = 16'hFC00;
  localparam logic [LP_W-1:0] LIST_OFS_MASK  = 16'h03FF;
  localparam logic [LP_W-1:0] SCAN_PAGE_MASK = 16'hF000;
  localparam logic [LP_W-1:0] SCAN_OFS_MASK  = 16'h0FFF;

  localparam logic [7:0]      LINE_CYCLES    = 8'd192;
  localparam logic [7:0]      HBLANK_CYCLES  = 8'd36;
  localparam logic [VL_W-1:0] VIS_FIRST      = 9'd24;
  localparam logic [VL_W-1:0] VIS_END        = 9'd216;
  localparam logic [VL_W-1:0] VBLANK_LINE    = 9'd240;
  localparam logic [VL_W-1:0] FRAME_LINES    = 9'd262;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_INST   = 7'b0000010,
    PH_JLO    = 7'b0000100,
    PH_JHI    = 7'b0001000,
    PH_SLO    = 7'b0010000,
    PH_SHI    = 7'b0100000,
    PH_SCREEN = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       action;
    logic [7:0] read_data;
  } in_t;

  typedef struct packed {
    logic            kind;
    logic [LP_W-1:0] read_address;
    logic [7:0]      cycles;
    logic            halt_cpu;
    logic            ready_pulse;
    logic            nmi_pulse;
    logic [1:0]      nmi_status;
    logic [VL_W-1:0] line_number;
    logic [7:0]      line_in_block;
    logic [3:0]      mode;
    logic            render_line;
    logic [BW_W-1:0] line_width;
  } res_t;

  // lines per block for display modes 2..15
  function automatic logic [7:0] block_lines(input logic [3:0] mode);
    logic [7:0] n;
    unique case (mode)
      4'd2, 4'd4, 4'd5, 4'd6, 4'd8: n = 8'd8;
      4'd3:                         n = 8'd10;
      4'd7:                         n = 8'd16;
      4'd9, 4'd10:                  n = 8'd4;
      4'd11, 4'd13:                 n = 8'd2;
      4'd12, 4'd14, 4'd15:          n = 8'd1;
      default:                      n = 8'd8;
    endcase
    return n;
  endfunction

  // bytes per line in narrow width for display modes 2..15
  function automatic logic [BW_W-1:0] narrow_bytes(input logic [3:0] mode);
    logic [BW_W-1:0] n;
    unique case (mode)
      4'd6, 4'd7, 4'd10, 4'd11, 4'd12: n = 6'd16;
      4'd8, 4'd9:                      n = 6'd8;
      default:                         n = 6'd32;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

[rtl/dlls_stream_if.sv]
`default_nettype none
interface dlls_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/dlls_ram.sv]
`default_nettype none
module dlls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/display_list_line_sequencer_core.sv]
// Display-list line sequencer: a tick word advances the current scanline by
// one timing phase, a data word returns the byte of the outstanding memory
// read. Each accepted word yields at most one result word, either a read
// request (address to fetch) or a finished phase with its cycle count, the
// halt/ready/interrupt pulses and line status. The block takes one input
// word per clock unless the output buffer is full; the decode and pointer
// update of one word is a read-modify-write of the sequencing registers,
// and screen bytes go to the line store RAM through its write port, one
// byte per returned word. Results pass through a two-word output buffer;
// the input stalls only while both words are held. The user is to write
// configuration only while the block is idle; the block does not enforce
// this. A write of the list start register also reloads the list pointer.
`default_nettype none
module display_list_line_sequencer_core #(
  parameter int unsigned LINE_STORE_BYTES = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  dlls_stream_if.sink                      in_ch,
  dlls_stream_if.source                    out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [dlls_pkg::CIDX_W-1:0] cfg_idx,
  input  wire logic [dlls_pkg::CFG_W-1:0]  cfg_data
);
  localparam int unsigned LS_AW = $clog2(LINE_STORE_BYTES);

  logic [5:0]                  dma_r;
  logic [7:0]                  nmien_r;
  logic [dlls_pkg::LP_W-1:0]   lp_r, lp_nxt;
  logic [7:0]                  instr_r, instr_nxt;
  logic [dlls_pkg::LP_W-1:0]   scan_r, scan_nxt;
  logic [3:0]                  mode_r, mode_nxt;
  logic [dlls_pkg::BW_W-1:0]   bw_r, bw_nxt;
  logic [7:0]                  blen_r, blen_nxt;
  logic [7:0]                  bline_r, bline_nxt;
  logic [7:0]                  hpos_r, hpos_nxt;
  logic [dlls_pkg::VL_W-1:0]   vline_r, vline_nxt;
  logic [1:0]                  flags_r, flags_nxt;
  dlls_pkg::phase_t            phase_r, phase_nxt;
  logic [dlls_pkg::BW_W-1:0]   fidx_r, fidx_nxt;
  logic [7:0]                  latch_r, latch_nxt;

  dlls_pkg::res_t              out_r, skid_r, res;
  logic                        out_valid_r, skid_valid_r;
  logic                        has_res;
  logic                        ls_we;

  logic  acc, out_fire;
  assign in_ch.ready   = !skid_valid_r;
  assign acc           = in_ch.valid && in_ch.ready;
  assign out_fire      = out_valid_r && out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_r;

  function automatic logic [dlls_pkg::LP_W-1:0] list_inc(input logic [dlls_pkg::LP_W-1:0] p);
    return (p & dlls_pkg::LIST_PAGE_MASK) | ((p + 16'd1) & dlls_pkg::LIST_OFS_MASK);
  endfunction

  always_comb begin
    logic                      do_req, do_start, do_fin;
    logic [dlls_pkg::LP_W-1:0] req_addr;
    logic [7:0]                cyc, bl1;
    logic                      ready_p, nmi_p, render, halt;
    logic [dlls_pkg::VL_W-1:0] vl1, vdiff;
    logic [1:0]                wm;
    logic [dlls_pkg::BW_W-1:0] n;
    logic [dlls_pkg::BW_W-1:0] fi1;
    logic [7:0]                d;

    lp_nxt    = lp_r;
    instr_nxt = instr_r;
    scan_nxt  = scan_r;
    mode_nxt  = mode_r;
    bw_nxt    = bw_r;
    blen_nxt  = blen_r;
    bline_nxt = bline_r;
    hpos_nxt  = hpos_r;
    vline_nxt = vline_r;
    flags_nxt = flags_r;
    phase_nxt = phase_r;
    fidx_nxt  = fidx_r;
    latch_nxt = latch_r;
    ls_we     = 1'b0;

    do_req   = 1'b0;
    do_start = 1'b0;
    do_fin   = 1'b0;
    has_res  = 1'b0;
    req_addr = '0;
    cyc      = '0;
    ready_p  = 1'b0;
    nmi_p    = 1'b0;
    render   = 1'b0;
    halt     = 1'b0;
    vl1      = vline_r + 9'd1;
    bl1      = bline_r + 8'd1;
    vdiff    = dlls_pkg::VBLANK_LINE - vline_r;
    wm       = dma_r[1:0];
    n        = '0;
    fi1      = fidx_r + 6'd1;
    d        = in_ch.data.read_data;

    if (acc && in_ch.data.action == dlls_pkg::ACT_TICK && phase_r == dlls_pkg::PH_IDLE) begin
      has_res = 1'b1;
      if (vline_r < dlls_pkg::VBLANK_LINE) begin
        render = (vline_r >= dlls_pkg::VIS_FIRST) && (vline_r < dlls_pkg::VIS_END);
        if (bline_r == 8'd0 && hpos_r == 8'd0) begin
          if (!dma_r[5]) begin
            hpos_nxt = dlls_pkg::LINE_CYCLES;
            cyc      = dlls_pkg::LINE_CYCLES;
          end else begin
            phase_nxt = dlls_pkg::PH_INST;
            do_req    = 1'b1;
            req_addr  = lp_r;
          end
        end else if (hpos_r < dlls_pkg::LINE_CYCLES) begin
          cyc      = dlls_pkg::LINE_CYCLES - hpos_r;
          hpos_nxt = dlls_pkg::LINE_CYCLES;
        end else begin
          render   = 1'b0;
          hpos_nxt = '0;
          if (bl1 == blen_r) begin
            bline_nxt = '0;
            if (instr_r[7] && nmien_r[7]) begin
              flags_nxt = flags_r | 2'b10;
              nmi_p     = 1'b1;
            end
          end else begin
            bline_nxt = bl1;
          end
          vline_nxt = vl1;
          cyc       = dlls_pkg::HBLANK_CYCLES;
          ready_p   = 1'b1;
        end
      end else if (hpos_r == 8'd0) begin
        if (vline_r == dlls_pkg::VBLANK_LINE && nmien_r[6]) begin
          flags_nxt = flags_r | 2'b01;
          nmi_p     = 1'b1;
        end
        hpos_nxt = dlls_pkg::LINE_CYCLES;
        cyc      = dlls_pkg::LINE_CYCLES;
      end else begin
        hpos_nxt  = '0;
        vline_nxt = (vl1 >= dlls_pkg::FRAME_LINES) ? '0 : vl1;
        cyc       = dlls_pkg::HBLANK_CYCLES;
        ready_p   = 1'b1;
      end
    end else if (acc && in_ch.data.action == dlls_pkg::ACT_DATA &&
                 phase_r != dlls_pkg::PH_IDLE) begin
      has_res = 1'b1;
      unique case (phase_r)
        dlls_pkg::PH_INST: begin
          instr_nxt = d;
          lp_nxt    = list_inc(lp_r);
          if (d[3:0] == dlls_pkg::OP_BLANK) begin
            mode_nxt = '0;
            bw_nxt   = '0;
            blen_nxt = {5'd0, d[6:4]} + 8'd1;
            do_fin   = 1'b1;
          end else if (d[3:0] == dlls_pkg::OP_JUMP) begin
            phase_nxt = dlls_pkg::PH_JLO;
            do_req    = 1'b1;
            req_addr  = lp_nxt;
          end else begin
            mode_nxt = d[3:0];
            if (d[6]) begin
              phase_nxt = dlls_pkg::PH_SLO;
              do_req    = 1'b1;
              req_addr  = lp_nxt;
            end else begin
              do_start = 1'b1;
            end
          end
        end
        dlls_pkg::PH_JLO, dlls_pkg::PH_SLO: begin
          latch_nxt = d;
          lp_nxt    = list_inc(lp_r);
          phase_nxt = (phase_r == dlls_pkg::PH_JLO) ? dlls_pkg::PH_JHI : dlls_pkg::PH_SHI;
          do_req    = 1'b1;
          req_addr  = lp_nxt;
        end
        dlls_pkg::PH_JHI: begin
          lp_nxt   = {d, latch_r};
          mode_nxt = '0;
          bw_nxt   = '0;
          blen_nxt = instr_r[6] ? vdiff[7:0] : 8'd1;
          do_fin   = 1'b1;
        end
        dlls_pkg::PH_SHI: begin
          lp_nxt   = list_inc(lp_r);
          scan_nxt = {d, latch_r};
          do_start = 1'b1;
        end
        dlls_pkg::PH_SCREEN: begin
          ls_we    = {1'b0, fidx_r} < 7'(LINE_STORE_BYTES);
          scan_nxt = (scan_r & dlls_pkg::SCAN_PAGE_MASK) |
                     ((scan_r + 16'd1) & dlls_pkg::SCAN_OFS_MASK);
          fidx_nxt = fi1;
          if (fi1 >= bw_r) begin
            do_fin = 1'b1;
          end else begin
            do_req   = 1'b1;
            req_addr = scan_nxt;
          end
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end

    // open the screen fetch of a mode line, or finish the line when the DMA width is zero
    if (do_start) begin
      blen_nxt = dlls_pkg::block_lines(mode_nxt);
      if (wm == 2'd0) begin
        bw_nxt = '0;
        do_fin = 1'b1;
      end else begin
        if (wm != 2'd3 && instr_nxt[4]) begin
          wm = wm + 2'd1;
        end
        n = dlls_pkg::narrow_bytes(mode_nxt);
        unique case (wm)
          2'd1:    bw_nxt = n;
          2'd2:    bw_nxt = n + (n >> 2);
          default: bw_nxt = n + (n >> 1);
        endcase
        fidx_nxt  = '0;
        phase_nxt = dlls_pkg::PH_SCREEN;
        do_req    = 1'b1;
        req_addr  = scan_nxt;
      end
    end

    // close the DMA phase of the line
    if (do_fin) begin
      cyc = 8'd2 + {2'd0, bw_nxt};
      if (instr_nxt[3:0] == dlls_pkg::OP_JUMP ||
          (instr_nxt[3:0] != dlls_pkg::OP_BLANK && instr_nxt[6])) begin
        cyc = cyc + 8'd4;
      end
      hpos_nxt  = hpos_r + cyc;
      phase_nxt = dlls_pkg::PH_IDLE;
      halt      = 1'b1;
    end

    res.kind          = do_req ? dlls_pkg::KIND_REQ : dlls_pkg::KIND_PHASE;
    res.read_address  = do_req ? req_addr : '0;
    res.cycles        = do_req ? 8'd0 : cyc;
    res.halt_cpu      = do_req | halt;
    res.ready_pulse   = do_req ? 1'b0 : ready_p;
    res.nmi_pulse     = do_req ? 1'b0 : nmi_p;
    res.nmi_status    = flags_nxt;
    res.line_number   = vline_nxt;
    res.line_in_block = bline_nxt;
    res.mode          = mode_nxt;
    res.render_line   = do_req ? 1'b0 : render;
    res.line_width    = bw_nxt;
  end

  dlls_ram #(
    .WIDTH (8),
    .DEPTH (LINE_STORE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (fidx_r[LS_AW-1:0]),
    .wdata (in_ch.data.read_data),
    .raddr (fidx_r[LS_AW-1:0]),
    .rdata ()
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dma_r        <= '0;
      nmien_r      <= '0;
      lp_r         <= '0;
      instr_r      <= '0;
      scan_r       <= '0;
      mode_r       <= '0;
      bw_r         <= '0;
      blen_r       <= '0;
      bline_r      <= '0;
      hpos_r       <= '0;
      vline_r      <= '0;
      flags_r      <= '0;
      phase_r      <= dlls_pkg::PH_IDLE;
      fidx_r       <= '0;
      latch_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      instr_r <= instr_nxt;
      scan_r  <= scan_nxt;
      mode_r  <= mode_nxt;
      bw_r    <= bw_nxt;
      blen_r  <= blen_nxt;
      bline_r <= bline_nxt;
      hpos_r  <= hpos_nxt;
      vline_r <= vline_nxt;
      flags_r <= flags_nxt;
      phase_r <= phase_nxt;
      fidx_r  <= fidx_nxt;
      latch_r <= latch_nxt;
      // a list start write reloads the list pointer
      lp_r    <= (cfg_we && cfg_idx == dlls_pkg::REG_LIST_START) ? cfg_data : lp_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          dlls_pkg::REG_DMA_CONTROL: dma_r   <= cfg_data[5:0];
          dlls_pkg::REG_NMI_ENABLE:  nmien_r <= cfg_data[7:0];
          dlls_pkg::REG_LIST_START:  ;
          default: ;
        endcase
      end
      // output buffer: drain skid first, else fill the output word or the skid word
      if (skid_valid_r) begin
        if (out_fire) begin
          skid_valid_r <= 1'b0;
        end
      end else if (has_res) begin
        if (out_valid_r && !out_fire) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (has_res) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/dlls_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module dlls_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire dlls_pkg::res_t out_data
);
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_NXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid && in_ready)
  `ASSERT_IMP(a_req_fields, clk, rst_n, out_valid && out_data.kind == dlls_pkg::KIND_REQ, out_data.halt_cpu && out_data.cycles == 8'd0 && !out_data.nmi_pulse && !out_data.ready_pulse)
  `ASSERT_IMP(a_eol_fields, clk, rst_n, out_valid && out_data.kind == dlls_pkg::KIND_PHASE && out_data.ready_pulse, out_data.cycles == dlls_pkg::HBLANK_CYCLES && out_data.line_number < dlls_pkg::FRAME_LINES)
  `ASSERT_NXT(a_stall_busy, clk, rst_n, in_valid && !in_ready && !out_ready, !in_ready && out_valid)
endmodule

bind display_list_line_sequencer_core dlls_checker u_dlls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire

[dv/tb_display_list_line_sequencer_core.sv]
`timescale 1ns / 100ps
module tb_display_list_line_sequencer_core;
  import dlls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 123;
  localparam int SETTLE_CYCLES = 8;

  // lines per block and narrow bytes per line, modes 2..15
  localparam logic [7:0] BLOCK_LINES [14] = '{8, 10, 8, 8, 8, 16, 8, 4, 4, 2, 1, 2, 1, 1};
  localparam logic [5:0] NARROW_BYTES [14] =
    '{32, 32, 32, 32, 16, 16, 8, 8, 16, 16, 16, 32, 32, 32};

  typedef struct {
    logic       act;
    logic [7:0] d;
    bit         typed;
    res_t       exp;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]    cfg_data;

  dlls_stream_if #(.payload_t(in_t))  in_ch ();
  dlls_stream_if #(.payload_t(res_t)) out_ch ();

  display_list_line_sequencer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // sequencer model state
  logic [5:0]  m_dma;
  logic [7:0]  m_nmien;
  logic [15:0] lp;
  logic [7:0]  instr;
  logic [15:0] scan;
  logic [3:0]  cur_mode;
  logic [5:0]  bw;
  logic [7:0]  blk_len;
  logic [7:0]  blk_line;
  logic [7:0]  hpos;
  logic [8:0]  vline;
  logic [1:0]  flags;
  phase_t      ph;
  logic [5:0]  fidx;
  logic        vblank_f;
  logic [7:0]  lo_latch;

  res_t        predicted_words [$];
  int          mismatches;
  int          cycle_count;
  int          send_pct;
  int          recv_pct;
  bit          dir_typed;
  res_t        dir_exp;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_pct);

  function automatic logic [15:0] next_lp(input logic [15:0] p);
    return (p & LIST_PAGE_MASK) | ((p + 16'd1) & LIST_OFS_MASK);
  endfunction

  function automatic res_t pack_res(input logic kind, input logic [15:0] addr,
                                    input logic [7:0] cyc, input logic halt,
                                    input logic rdy, input logic nmi, input logic render);
    res_t r;
    r.kind          = kind;
    r.read_address  = addr;
    r.cycles        = cyc;
    r.halt_cpu      = halt;
    r.ready_pulse   = rdy;
    r.nmi_pulse     = nmi;
    r.nmi_status    = flags;
    r.line_number   = vline;
    r.line_in_block = blk_line;
    r.mode          = cur_mode;
    r.render_line   = render;
    r.line_width    = bw;
    return r;
  endfunction

  task automatic close_fetch(output res_t r);
    logic [7:0] cyc;
    cyc = 8'd2;
    if (instr[3:0] == OP_JUMP || (instr[3:0] != OP_BLANK && instr[6]))
      cyc = cyc + 8'd4;
    cyc = cyc + {2'b00, bw};
    hpos = hpos + cyc;
    ph = PH_IDLE;
    r = pack_res(KIND_PHASE, 16'h0000, cyc, 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic open_screen(output res_t r);
    logic [1:0] wm;
    logic [5:0] n;
    logic [3:0] ix;
    wm = m_dma[1:0];
    ix = cur_mode - 4'd2;
    blk_len = BLOCK_LINES[ix];
    if (wm == 2'd0) begin
      bw = 6'd0;
      close_fetch(r);
    end else begin
      // horizontal scroll widens by one step, up to wide
      if (wm < 2'd3 && instr[4])
        wm = wm + 2'd1;
      n = NARROW_BYTES[ix];
      case (wm)
        2'd1: bw = n;
        2'd2: bw = n + n / 4;
        default: bw = n + n / 2;
      endcase
      fidx = 6'd0;
      ph = PH_SCREEN;
      r = pack_res(KIND_REQ, scan, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
    end
  endtask

  task automatic take_byte(input logic [7:0] d, output res_t r);
    case (ph)
      PH_INST: begin
        instr = d;
        lp = next_lp(lp);
        if (d[3:0] == OP_BLANK) begin
          cur_mode = 4'd0;
          bw = 6'd0;
          blk_len = {5'd0, d[6:4]} + 8'd1;
          close_fetch(r);
        end else if (d[3:0] == OP_JUMP) begin
          ph = PH_JLO;
          r = pack_res(KIND_REQ, lp, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        end else begin
          cur_mode = d[3:0];
          if (d[6]) begin
            ph = PH_SLO;
            r = pack_res(KIND_REQ, lp, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
          end else begin
            open_screen(r);
          end
        end
      end
      PH_JLO, PH_SLO: begin
        lo_latch = d;
        lp = next_lp(lp);
        ph = (ph == PH_JLO) ? PH_JHI : PH_SHI;
        r = pack_res(KIND_REQ, lp, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
      end
      PH_JHI: begin
        lp = {d, lo_latch};
        cur_mode = 4'd0;
        bw = 6'd0;
        // wait for vblank: hold the block until line 240
        blk_len = instr[6] ? 8'(VBLANK_LINE - vline) : 8'd1;
        close_fetch(r);
      end
      PH_SHI: begin
        lp = next_lp(lp);
        scan = {d, lo_latch};
        open_screen(r);
      end
      default: begin
        scan = (scan & SCAN_PAGE_MASK) | ((scan + 16'd1) & SCAN_OFS_MASK);
        fidx = fidx + 6'd1;
        if (fidx >= bw)
          close_fetch(r);
        else
          r = pack_res(KIND_REQ, scan, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
      end
    endcase
  endtask

  task automatic take_tick(output res_t r);
    logic vis;
    logic nmi;
    logic [7:0] cyc;
    vis = (vline >= VIS_FIRST && vline < VIS_END);
    nmi = 1'b0;
    if (vline < VBLANK_LINE) begin
      if (blk_line == 8'd0 && hpos == 8'd0) begin
        if (!m_dma[5]) begin
          hpos = LINE_CYCLES;
          r = pack_res(KIND_PHASE, 16'h0000, LINE_CYCLES, 1'b0, 1'b0, 1'b0, vis);
        end else begin
          ph = PH_INST;
          r = pack_res(KIND_REQ, lp, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        end
      end else if (hpos < LINE_CYCLES) begin
        cyc = LINE_CYCLES - hpos;
        hpos = LINE_CYCLES;
        r = pack_res(KIND_PHASE, 16'h0000, cyc, 1'b0, 1'b0, 1'b0, vis);
      end else begin
        hpos = 8'd0;
        blk_line = blk_line + 8'd1;
        if (blk_line == blk_len) begin
          blk_line = 8'd0;
          if (instr[7] && m_nmien[7]) begin
            flags = flags | 2'b10;
            nmi = 1'b1;
          end
        end
        vline = vline + 9'd1;
        r = pack_res(KIND_PHASE, 16'h0000, HBLANK_CYCLES, 1'b0, 1'b1, nmi, 1'b0);
      end
    end else begin
      vblank_f = 1'b1;
      if (hpos == 8'd0) begin
        if (vline == VBLANK_LINE && m_nmien[6]) begin
          flags = flags | 2'b01;
          nmi = 1'b1;
        end
        hpos = LINE_CYCLES;
        r = pack_res(KIND_PHASE, 16'h0000, LINE_CYCLES, 1'b0, 1'b0, nmi, 1'b0);
      end else begin
        hpos = 8'd0;
        vline = vline + 9'd1;
        if (vline >= FRAME_LINES) begin
          vline = 9'd0;
          vblank_f = 1'b0;
        end
        r = pack_res(KIND_PHASE, 16'h0000, HBLANK_CYCLES, 1'b0, 1'b1, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic step_sequencer(input in_t w, output bit has, output res_t r);
    has = 1'b0;
    r = '0;
    // drop data while idle and ticks while a read is outstanding
    if (w.action == ACT_DATA) begin
      if (ph != PH_IDLE) begin
        has = 1'b1;
        take_byte(w.read_data, r);
      end
    end else if (ph == PH_IDLE) begin
      has = 1'b1;
      take_tick(r);
    end
  endtask

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    bit   has;
    res_t r;
    res_t e;
    if (!rst_n) begin
      m_dma = '0; m_nmien = '0; lp = '0; instr = '0; scan = '0; cur_mode = '0;
      bw = '0; blk_len = '0; blk_line = '0; hpos = '0; vline = '0; flags = '0;
      ph = PH_IDLE; fidx = '0; vblank_f = 1'b0; lo_latch = '0;
      predicted_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_DMA_CONTROL: m_dma = cfg_data[5:0];
          REG_NMI_ENABLE:  m_nmien = cfg_data[7:0];
          REG_LIST_START:  lp = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        step_sequencer(in_ch.data, has, r);
        if (has)
          predicted_words.push_back(dir_typed ? dir_exp : r);
      end
      if (out_ch.valid && out_ch.ready) begin
        r = out_ch.data;
        if (predicted_words.size() == 0) begin
          $error("result word with nothing expected: 0x%0h", r);
          mismatches++;
        end else begin
          e = predicted_words.pop_front();
          check_field("kind", e.kind, r.kind);
          check_field("read_address", e.read_address, r.read_address);
          check_field("cycles", e.cycles, r.cycles);
          check_field("halt_cpu", e.halt_cpu, r.halt_cpu);
          check_field("ready_pulse", e.ready_pulse, r.ready_pulse);
          check_field("nmi_pulse", e.nmi_pulse, r.nmi_pulse);
          check_field("nmi_status", e.nmi_status, r.nmi_status);
          check_field("line_number", e.line_number, r.line_number);
          check_field("line_in_block", e.line_in_block, r.line_in_block);
          check_field("mode", e.mode, r.mode);
          check_field("render_line", e.render_line, r.render_line);
          check_field("line_width", e.line_width, r.line_width);
        end
      end
    end
  end

  task automatic sender_gap();
    @(negedge clk);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic push_word(input logic act, input logic [7:0] d, input bit typed,
                           input res_t t);
    in_ch.valid <= 1'b1;
    in_ch.data  <= in_t'{act, d};
    dir_typed   <= typed;
    dir_exp     <= t;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (predicted_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [5:0] dma, input logic [7:0] nmi,
                            input logic [15:0] lst);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_DMA_CONTROL;
    cfg_data <= {10'd0, dma};
    @(negedge clk);
    cfg_idx  <= REG_NMI_ENABLE;
    cfg_data <= {8'd0, nmi};
    @(negedge clk);
    cfg_idx  <= REG_LIST_START;
    cfg_data <= lst;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    dir_row_t    dir_rows [$];
    int          send_pcts [4];
    int          recv_pcts [4];
    int          counted;
    bit          noise;
    logic        act;
    logic [7:0]  d;
    logic [5:0]  dma;
    logic [7:0]  nmi;
    logic [15:0] lst;
    send_pcts = '{0, 53, 0, 38};
    recv_pcts = '{0, 0, 53, 38};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    dir_typed = 1'b0;
    dir_exp = '0;
    send_pct = 0;
    recv_pct = 0;
    mismatches = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fields: kind, addr, cycles, halt, ready, nmi, status, line, block line,
    // mode, render, width
    dir_rows.push_back('{ACT_DATA, 8'h55, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_TICK, 8'h00, 1'b1, res_t'{KIND_REQ, 16'h13FE, 8'd0,
      1'b1, 1'b0, 1'b0, 2'd0, 9'd0, 8'd0, 4'd0, 1'b0, 6'd0}});
    dir_rows.push_back('{ACT_TICK, 8'hFF, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'h80, 1'b1, res_t'{KIND_PHASE, 16'h0000, 8'd2,
      1'b1, 1'b0, 1'b0, 2'd0, 9'd0, 8'd0, 4'd0, 1'b0, 6'd0}});
    dir_rows.push_back('{ACT_TICK, 8'h00, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_TICK, 8'h00, 1'b1, res_t'{KIND_PHASE, 16'h0000, 8'd36,
      1'b0, 1'b1, 1'b1, 2'd2, 9'd1, 8'd0, 4'd0, 1'b0, 6'd0}});
    dir_rows.push_back('{ACT_TICK, 8'h00, 1'b0, res_t'(0)});
    // mode 8 with scan load, scroll widening and interrupt bit
    dir_rows.push_back('{ACT_DATA, 8'hD8, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'hFF, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'h2F, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'h00, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'hA5, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'h5A, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'h01, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'h80, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'h7F, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'hFE, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'h33, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'hCC, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_DATA, 8'hFF, 1'b1, res_t'{KIND_PHASE, 16'h0000, 8'd16,
      1'b1, 1'b0, 1'b0, 2'd2, 9'd1, 8'd0, 4'd8, 1'b0, 6'd10}});
    dir_rows.push_back('{ACT_TICK, 8'h00, 1'b0, res_t'(0)});
    dir_rows.push_back('{ACT_TICK, 8'h00, 1'b0, res_t'(0)});

    write_regs(6'h21, 8'hC0, 16'h13FE);
    foreach (dir_rows[i]) begin
      sender_gap();
      push_word(dir_rows[i].act, dir_rows[i].d, dir_rows[i].typed, dir_rows[i].exp);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin dma = 6'h20; nmi = 8'h00; lst = 16'h0000; end
        1: begin dma = 6'h3F; nmi = 8'hFF; lst = 16'hFFFF; end
        2: begin dma = 6'h00; nmi = 8'hC0; lst = 16'h03FF; end
        3: begin dma = 6'h21; nmi = 8'h40; lst = 16'($urandom); end
        4: begin dma = 6'h22; nmi = 8'h80; lst = 16'hFC00; end
        5: begin dma = 6'($urandom) | 6'h20; nmi = 8'($urandom); lst = 16'($urandom); end
        6: begin dma = 6'h23; nmi = 8'hFF; lst = 16'($urandom); end
        7: begin dma = 6'h1F; nmi = 8'h3F; lst = 16'h8000; end
        8: begin dma = 6'h3C; nmi = 8'hC0; lst = 16'($urandom); end
        default: begin dma = 6'($urandom); nmi = 8'($urandom); lst = 16'($urandom); end
      endcase
      write_regs(dma, nmi, lst);
      send_pct = send_pcts[p % 4];
      recv_pct = recv_pcts[p % 4];
      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        sender_gap();
        noise = ($urandom_range(99) < 8);
        if (ph == PH_IDLE)
          act = noise ? ACT_DATA : ACT_TICK;
        else
          act = noise ? ACT_TICK : ACT_DATA;
        d = 8'($urandom_range(255));
        // bias instruction bytes toward blanks and jumps to reach vblank
        if (!noise && ph == PH_INST) begin
          case ($urandom_range(99)) inside
            [0:24]:  d[3:0] = OP_BLANK;
            [25:39]: d[3:0] = OP_JUMP;
            default: d[3:0] = 4'($urandom_range(15, 2));
          endcase
        end
        push_word(act, d, 1'b0, res_t'(0));
        if (!noise)
          counted++;
      end
      drain();
    end

    if (mismatches == 0 && predicted_words.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
